// File: rtl/sacl_pkg.sv
// Shared constants and codes for the set-associative cache tag lookup.
package sacl_pkg;

    localparam int unsigned MAX_SET_BITS_DEF = 7;
    localparam int unsigned WAYS_DEF         = 4;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned TAG_W       = 32;
    localparam int unsigned WAY_OUT_W   = 2;

    localparam int unsigned IDX_CFG_W   = 3;
    localparam int unsigned OFF_CFG_W   = 4;
    localparam int unsigned WAYS_CFG_W  = 3;
    localparam int unsigned CFG_DATA_W  = 4;
    localparam int unsigned CFG_SEL_W   = 2;

    localparam logic [IDX_CFG_W-1:0]  INDEX_BITS_RST  = 3'd7;
    localparam logic [OFF_CFG_W-1:0]  OFFSET_BITS_RST = 4'd2;
    localparam logic [WAYS_CFG_W-1:0] WAYS_IN_USE_RST = 3'd1;

    typedef enum logic [CFG_SEL_W-1:0] {
        CFG_INDEX_BITS  = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } cfg_reg_t;

endpackage

// File: rtl/sacl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sacl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/set_assoc_cache_lru_lookup.sv
// Set-associative tag lookup with LRU replacement. One address request is taken per cycle
// while in_stall is low; the lookup stage registers it and writes its hit/way result to the output
// register when it advances. Each set is one row of a single-port-write RAM (valid, rank and tag
// of every way), read at acceptance and written back when the lookup stage advances; a request to
// the set written at the same edge takes the row from the write-back register instead of the RAM.
// After reset the block clears every row (2**MAX_SET_BITS rows, 128 by default), one per cycle,
// before the first request is accepted; configuration writes are taken meanwhile.
module set_assoc_cache_lru_lookup #(
    parameter int unsigned MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
    parameter int unsigned WAYS         = sacl_pkg::WAYS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [sacl_pkg::CFG_SEL_W-1:0]   cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [sacl_pkg::ADDR_W-1:0]      address,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]   way
);

    import sacl_pkg::*;

    localparam int unsigned SET_W   = MAX_SET_BITS;
    localparam int unsigned SETS    = 1 << MAX_SET_BITS;
    localparam int unsigned RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned IB_W    = $clog2(MAX_SET_BITS + 1);
    localparam int unsigned ROW_W   = WAYS * (1 + RANK_W + TAG_W);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

    // configuration
    logic [IDX_CFG_W-1:0]  index_bits_reg;
    logic [OFF_CFG_W-1:0]  offset_bits_reg;
    logic [WAYS_CFG_W-1:0] ways_in_use_reg;

    // clearing pass
    logic             clr_busy_reg;
    logic [SET_W-1:0] clr_cnt_reg;

    // lookup stage
    logic              s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [SET_W-1:0]  s1_set_reg;
    logic              fwd_sel_reg;
    logic [ROW_W-1:0]  fwd_row_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg;
    logic [WAY_OUT_W-1:0] way_reg;

    logic              in_accept;
    logic              s1_adv;
    logic              s1_fire;
    logic [IB_W-1:0]   ib_eff;
    logic [SET_W-1:0]  set_mask;
    logic [SET_W-1:0]  in_set;
    logic [5:0]        tag_sh;
    logic [TAG_W-1:0]  tag;
    logic [WAYS-1:0]   way_en;

    logic [ROW_W-1:0]  ram_rd_data;
    logic [ROW_W-1:0]  cur_row;
    logic              ram_wr_en;
    logic [SET_W-1:0]  ram_wr_addr;
    logic [ROW_W-1:0]  ram_wr_data;

    logic [WAYS-1:0]                  cur_valid;
    logic [WAYS-1:0][RANK_W-1:0]      cur_rank;
    logic [WAYS-1:0][TAG_W-1:0]       cur_tag;
    logic [WAYS-1:0]                  new_valid;
    logic [WAYS-1:0][RANK_W-1:0]      new_rank;
    logic [WAYS-1:0][TAG_W-1:0]       new_tag;
    logic [ROW_W-1:0]                 new_row;

    logic              hit_found;
    logic              free_found;
    logic [WAY_W-1:0]  hit_w;
    logic [WAY_W-1:0]  free_w;
    logic [WAY_W-1:0]  vic_w;
    logic [WAY_W-1:0]  sel_w;
    logic [RANK_W-1:0] best;
    logic [RANK_W-1:0] lim;
    logic              age_all;
    logic [WAY_W+WAY_OUT_W-1:0] way_ext;

    // ---------------- address split ----------------
    always_comb
    begin
        if (int'(index_bits_reg) > int'(MAX_SET_BITS))
        begin
            ib_eff = IB_W'(MAX_SET_BITS);
        end
        else
        begin
            ib_eff = IB_W'(index_bits_reg);
        end
    end

    assign set_mask = ~({SET_W{1'b1}} << ib_eff);
    assign in_set   = SET_W'(address >> offset_bits_reg) & set_mask;
    assign tag_sh   = 6'(offset_bits_reg) + 6'(ib_eff);
    assign tag      = s1_addr_reg >> tag_sh;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            way_en[i] = (i == 0) || (int'(ways_in_use_reg) > i);
        end
    end

    // ---------------- handshake ----------------
    assign s1_adv    = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign in_stall  = clr_busy_reg || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;

    // ---------------- set memory ----------------
    assign ram_wr_en   = clr_busy_reg || s1_fire;
    assign ram_wr_addr = clr_busy_reg ? clr_cnt_reg : s1_set_reg;
    assign ram_wr_data = clr_busy_reg ? '0 : new_row;

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_set_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (in_set),
        .rd_data (ram_rd_data)
    );

    // row written at the read edge is not in the RAM read data yet
    assign cur_row = fwd_sel_reg ? fwd_row_reg : ram_rd_data;
    assign {cur_valid, cur_rank, cur_tag} = cur_row;

    // ---------------- lookup and replacement ----------------
    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_w      = '0;
        free_w     = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (way_en[i] && cur_valid[i] && (cur_tag[i] == tag))
            begin
                hit_found = 1'b1;
                hit_w     = WAY_W'(i);
            end
            if (way_en[i] && !cur_valid[i])
            begin
                free_found = 1'b1;
                free_w     = WAY_W'(i);
            end
        end
    end

    // oldest in-use way, lowest index on a tie
    always_comb
    begin
        vic_w = '0;
        best  = cur_rank[0];
        for (int i = 1; i < WAYS; i++)
        begin
            if (way_en[i] && (cur_rank[i] > best))
            begin
                best  = cur_rank[i];
                vic_w = WAY_W'(i);
            end
        end
    end

    always_comb
    begin
        if (hit_found)
        begin
            sel_w = hit_w;
        end
        else if (free_found)
        begin
            sel_w = free_w;
        end
        else
        begin
            sel_w = vic_w;
        end
    end

    assign age_all = !hit_found && free_found;
    assign lim     = hit_found ? cur_rank[hit_w] : best;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_W'(i) == sel_w)
            begin
                new_valid[i] = 1'b1;
                new_tag[i]   = tag;
                new_rank[i]  = '0;
            end
            else
            begin
                new_valid[i] = cur_valid[i];
                new_tag[i]   = cur_tag[i];
                if (way_en[i] && cur_valid[i] && (age_all || (cur_rank[i] < lim)) &&
                    (cur_rank[i] < RANK_MAX))
                begin
                    new_rank[i] = cur_rank[i] + RANK_W'(1);
                end
                else
                begin
                    new_rank[i] = cur_rank[i];
                end
            end
        end
    end

    assign new_row = {new_valid, new_rank, new_tag};
    assign way_ext = {{WAY_OUT_W{1'b0}}, sel_w};

    // ---------------- control next state ----------------
    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg  <= INDEX_BITS_RST;
            offset_bits_reg <= OFFSET_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
            clr_busy_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INDEX_BITS:  index_bits_reg  <= IDX_CFG_W'(cfg_data);
                    CFG_OFFSET_BITS: offset_bits_reg <= OFF_CFG_W'(cfg_data);
                    CFG_WAYS_IN_USE: ways_in_use_reg <= WAYS_CFG_W'(cfg_data);
                    default:         ;
                endcase
            end
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == {SET_W{1'b1}})
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg <= address;
            s1_set_reg  <= in_set;
            fwd_sel_reg <= s1_fire && (s1_set_reg == in_set);
        end
        if (s1_fire)
        begin
            fwd_row_reg <= new_row;
            hit_reg     <= hit_found;
            way_reg     <= way_ext[WAY_OUT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign way       = way_reg;

    // ---------------- assertions ----------------
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("clearing pass restarted");

    a_stall_holds_row: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=>
            (s1_valid_reg && $stable(s1_addr_reg) && $stable(cur_row)))
        else $error("stalled lookup lost its set row");

    a_touch_mru: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> (new_valid[sel_w] && (new_rank[sel_w] == '0) && way_en[sel_w]))
        else $error("accessed way not valid, in use and most recent");

    a_hit_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && hit_found) |-> (cur_valid[sel_w] && (cur_tag[sel_w] == tag)))
        else $error("hit on a way whose tag differs");

endmodule
